// ===== hdl/integer_matrix_multiply_top_defines.svh =====
// assertion macros shared by the matrix multiply rtl
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define IMM_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("imm: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define IMM_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("imm: next-cycle check failed");

`endif

// ===== hdl/imm_pkg.sv =====
// shared types, constants and helpers of the matrix multiply block
package imm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ELEM_W     = 32;
  localparam int IDX_W      = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd3;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] product;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic                     last;
  } out_t;

  // last index of each dimension after saturation to 1..MAX_DIM
  typedef struct packed {
    logic [IDX_W-1:0] m_last;
    logic [IDX_W-1:0] n_last;
    logic [IDX_W-1:0] p_last;
  } dims_t;

  // store write strobes
  typedef struct packed {
    logic a_we;
    logic b_we;
  } wr_ctl_t;

  // multiply-accumulate issue tags
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } rd_ctl_t;

  function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_DATA_W-1:0] v,
                                                input int max_dim);
    int d;
    d = int'(v);
    if (d < 1) d = 1;
    if (d > max_dim) d = max_dim;
    return IDX_W'(d - 1);
  endfunction

endpackage

// ===== hdl/imm_stream_if.sv =====
// valid/ready stream channel with a typed payload
interface imm_stream_if #(
  parameter type payload_t = logic [31:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/imm_mac.sv =====
// matrix stores and the shared multiply-accumulate pipeline
module imm_mac #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  imm_pkg::wr_ctl_t      wr,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  imm_pkg::rd_ctl_t      rd,
  input  logic [AW-1:0]         a_addr,
  input  logic [AW-1:0]         b_addr,
  output logic                  sum_valid,
  output logic [DATA_WIDTH-1:0] sum
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [DATA_WIDTH-1:0] a_mem [DEPTH];
  logic [DATA_WIDTH-1:0] b_mem [DEPTH];

  logic [DATA_WIDTH-1:0] a_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] acc;
  rd_ctl_t               s1;
  rd_ctl_t               s2;

  always_ff @(posedge clk) begin
    if (wr.a_we) a_mem[wr_addr] <= wr_data;
    if (wr.b_we) b_mem[wr_addr] <= wr_data;
    a_q <= a_mem[a_addr];
    b_q <= b_mem[b_addr];
  end

  // product keeps the low bits only, sums wrap
  always_ff @(posedge clk) begin
    prod <= DATA_WIDTH'(a_q * b_q);
    if (s2.valid) begin
      acc <= s2.first ? prod : DATA_WIDTH'(acc + prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      sum_valid <= 1'b0;
    end else begin
      s1        <= rd;
      s2        <= s1;
      sum_valid <= s2.valid && s2.lastk;
    end
  end

  assign sum = acc;

endmodule

// ===== hdl/imm_ctrl.sv =====
// load counters, result sequencer and output register
`include "integer_matrix_multiply_top_defines.svh"

module imm_ctrl #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  imm_pkg::dims_t        dims,
  input  logic                  restart,
  imm_stream_if.sink            feed,
  imm_stream_if.source          result,
  output imm_pkg::wr_ctl_t      wr,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output imm_pkg::rd_ctl_t      rd,
  output logic [AW-1:0]         a_addr,
  output logic [AW-1:0]         b_addr,
  input  logic                  sum_valid,
  input  logic [DATA_WIDTH-1:0] sum
);
  import imm_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_WAIT,
    ST_PUSH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic             loading_b;
  logic [IDX_W-1:0] ci;
  logic [IDX_W-1:0] cj;
  logic [IDX_W-1:0] ck;
  logic             out_valid;

  logic                         take;
  logic                         push_ok;
  logic [IDX_W-1:0]             col_last;
  logic [IDX_W-1:0]             row_last;
  logic signed [DATA_WIDTH-1:0] sum_s;

  assign feed.ready = (state == ST_LOAD);
  assign take       = feed.valid && feed.ready;
  assign push_ok    = !out_valid || result.ready;
  assign col_last   = loading_b ? dims.p_last : dims.n_last;
  assign row_last   = loading_b ? dims.n_last : dims.m_last;
  assign sum_s      = sum;

  assign result.valid = out_valid;

  always_comb begin
    wr.a_we  = take && !loading_b;
    wr.b_we  = take && loading_b;
    wr_addr  = AW'(int'(row) * MAX_DIM + int'(col));
    wr_data  = feed.data.element[DATA_WIDTH-1:0];
    rd.valid = (state == ST_MAC);
    rd.first = (ck == '0);
    rd.lastk = (ck == dims.n_last);
    a_addr   = AW'(int'(ci) * MAX_DIM + int'(ck));
    b_addr   = AW'(int'(ck) * MAX_DIM + int'(cj));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      row       <= '0;
      col       <= '0;
      loading_b <= 1'b0;
      ci        <= '0;
      cj        <= '0;
      ck        <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one that leaves this cycle
      if (state == ST_PUSH && push_ok) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (restart) begin
            row       <= '0;
            col       <= '0;
            loading_b <= 1'b0;
          end else if (take) begin
            if (col == col_last) begin
              col <= '0;
              if (row == row_last) begin
                row       <= '0;
                loading_b <= !loading_b;
                // final element of b starts the products
                if (loading_b) state <= ST_MAC;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        ST_MAC: begin
          if (ck == dims.n_last) begin
            ck    <= '0;
            state <= ST_WAIT;
          end else begin
            ck <= ck + 1'b1;
          end
        end
        ST_WAIT: begin
          if (sum_valid) state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ok) begin
            result.data.product      <= ELEM_W'(sum_s);
            result.data.row_index    <= ci;
            result.data.col_index    <= cj;
            result.data.last         <= (ci == dims.m_last) && (cj == dims.p_last);
            if (cj == dims.p_last) begin
              cj <= '0;
              if (ci == dims.m_last) begin
                ci    <= '0;
                state <= ST_LOAD;
              end else begin
                ci    <= ci + 1'b1;
                state <= ST_MAC;
              end
            end else begin
              cj    <= cj + 1'b1;
              state <= ST_MAC;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  `IMM_ASSERT_NOW(sum_only_in_wait, sum_valid, state == ST_WAIT)
  `IMM_ASSERT_NOW(k_in_range, state == ST_MAC, ck <= dims.n_last)
  `IMM_ASSERT_NOW(load_in_range, state == ST_LOAD && !restart, row <= row_last && col <= col_last)
  `IMM_ASSERT_NEXT(last_b_starts, take && !restart && loading_b && row == row_last && col == col_last, state == ST_MAC && ci == '0 && cj == '0)

endmodule

// ===== hdl/integer_matrix_multiply_top.sv =====
// Integer matrix multiply. Elements of A (rows_a x inner_dim) and then B (inner_dim x cols_b)
// arrive row-major, one per transfer, into two stores with a write and a read port each.
// The transfer of the last B element starts the product: every element of C = A * B leaves
// row-major with its row, column and a last flag, sums wrapping at DATA_WIDTH bits and the
// result sign-extended to 32 bits. One shared multiplier and adder, fed one A/B pair a cycle
// from the stores while a result's products issue, make each result in turn; no input is
// taken until the last result is in the output register. A write to a dimension register
// while loading restarts the load at A[0][0]; dimensions of 0 act as 1 and above MAX_DIM as MAX_DIM.
module integer_matrix_multiply_top #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [imm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [imm_pkg::CFG_DATA_W-1:0]  cfg_data,
  imm_stream_if.sink                      feed,
  imm_stream_if.source                    result
);
  import imm_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic [CFG_DATA_W-1:0] rows_a;
  logic [CFG_DATA_W-1:0] inner_dim;
  logic [CFG_DATA_W-1:0] cols_b;
  logic                  restart;
  dims_t                 dims;

  wr_ctl_t               wr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  rd_ctl_t               rd;
  logic [AW-1:0]         a_addr;
  logic [AW-1:0]         b_addr;
  logic                  sum_valid;
  logic [DATA_WIDTH-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_addr == REG_ROWS_A || cfg_addr == REG_INNER_DIM ||
                              cfg_addr == REG_COLS_B);

  always_comb begin
    dims.m_last = dim_last(rows_a, MAX_DIM);
    dims.n_last = dim_last(inner_dim, MAX_DIM);
    dims.p_last = dim_last(cols_b, MAX_DIM);
  end

  imm_ctrl #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .restart   (restart),
    .feed      (feed),
    .result    (result),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd        (rd),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  imm_mac #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd        (rd),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

endmodule
